>>> design/kf2_pkg.sv
package kf2_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DIV_STEPS = DATA_W + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int MAG_W     = DIV_STEPS + 1;
  localparam int PC_W      = 7;
  localparam int NUM_RF    = 25;

  localparam logic [15:0] DT_RESET = 16'd1376;
  localparam logic [30:0] RD_RESET = 31'd163840;
  localparam logic [30:0] RV_RESET = 31'd6554;
  localparam logic [30:0] QA_RESET = 31'd393;

  localparam logic [DATA_W-1:0] FX_ONE  = DATA_W'(1) << FRAC_BITS;
  localparam logic [DATA_W-1:0] FX_HALF = DATA_W'(1) << (FRAC_BITS - 1);

  typedef enum logic [1:0] {
    CFG_TIME_STEP = 2'd0,
    CFG_POS_SD    = 2'd1,
    CFG_VEL_SD    = 2'd2,
    CFG_PROC_SD   = 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    R_X0, R_X1, R_P0, R_P1, R_P2, R_P3, R_ZD, R_ZV, R_U, R_B0, R_Q, R_T1, R_T2,
    R_S00, R_S11, R_DET, R_K00, R_K01, R_K10, R_K11, R_Y0, R_Y1, R_N00, R_N01,
    R_N10, R_DT, R_RD, R_RV, R_QA, R_HALF
  } reg_id_t;

  typedef enum logic [2:0] {
    OP_MUL, OP_ADD, OP_SUB, OP_DIV, OP_CHK, OP_CPY, OP_END
  } op_t;

  typedef struct packed {
    op_t     op;
    reg_id_t dst;
    reg_id_t sa;
    reg_id_t sb;
  } uop_t;

  typedef struct packed {
    logic              sat;
    logic [DATA_W-1:0] val;
  } fx_res_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [DATA_W-1:0] quo;
  } div_res_t;

  function automatic fx_res_t sat_mag(logic [MAG_W-1:0] m, logic neg);
    logic [MAG_W-1:0] lim;
    logic [DATA_W-1:0] v;
    fx_res_t res;
    lim = neg ? (MAG_W'(1) << (DATA_W - 1)) : ((MAG_W'(1) << (DATA_W - 1)) - MAG_W'(1));
    res.sat = (m > lim);
    v = res.sat ? lim[DATA_W-1:0] : m[DATA_W-1:0];
    res.val = neg ? (DATA_W'(0) - v) : v;
    return res;
  endfunction

  function automatic uop_t mk(op_t o, reg_id_t d, reg_id_t a, reg_id_t b);
    uop_t u;
    u.op = o;
    u.dst = d;
    u.sa = a;
    u.sb = b;
    return u;
  endfunction

  function automatic uop_t ucode(logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      7'd0:  u = mk(OP_MUL, R_T1,  R_DT,  R_DT);
      7'd1:  u = mk(OP_MUL, R_B0,  R_T1,  R_HALF);
      7'd2:  u = mk(OP_MUL, R_Q,   R_QA,  R_QA);
      7'd3:  u = mk(OP_MUL, R_T1,  R_DT,  R_X1);
      7'd4:  u = mk(OP_ADD, R_T1,  R_X0,  R_T1);
      7'd5:  u = mk(OP_MUL, R_T2,  R_B0,  R_U);
      7'd6:  u = mk(OP_ADD, R_X0,  R_T1,  R_T2);
      7'd7:  u = mk(OP_MUL, R_T1,  R_DT,  R_U);
      7'd8:  u = mk(OP_ADD, R_X1,  R_X1,  R_T1);
      7'd9:  u = mk(OP_MUL, R_T1,  R_DT,  R_P2);
      7'd10: u = mk(OP_ADD, R_T2,  R_P0,  R_T1);
      7'd11: u = mk(OP_MUL, R_T1,  R_DT,  R_P3);
      7'd12: u = mk(OP_ADD, R_P1,  R_P1,  R_T1);
      7'd13: u = mk(OP_MUL, R_T1,  R_P1,  R_DT);
      7'd14: u = mk(OP_ADD, R_T1,  R_T2,  R_T1);
      7'd15: u = mk(OP_ADD, R_P0,  R_T1,  R_Q);
      7'd16: u = mk(OP_MUL, R_T1,  R_P3,  R_DT);
      7'd17: u = mk(OP_ADD, R_P2,  R_P2,  R_T1);
      7'd18: u = mk(OP_ADD, R_P3,  R_P3,  R_Q);
      7'd19: u = mk(OP_MUL, R_T1,  R_RD,  R_RD);
      7'd20: u = mk(OP_ADD, R_S00, R_P0,  R_T1);
      7'd21: u = mk(OP_MUL, R_T1,  R_RV,  R_RV);
      7'd22: u = mk(OP_ADD, R_S11, R_P3,  R_T1);
      7'd23: u = mk(OP_MUL, R_T1,  R_S00, R_S11);
      7'd24: u = mk(OP_MUL, R_T2,  R_P1,  R_P2);
      7'd25: u = mk(OP_SUB, R_DET, R_T1,  R_T2);
      7'd26: u = mk(OP_CHK, R_T1,  R_DET, R_DET);
      7'd27: u = mk(OP_MUL, R_T1,  R_P0,  R_S11);
      7'd28: u = mk(OP_MUL, R_T2,  R_P1,  R_P2);
      7'd29: u = mk(OP_SUB, R_T1,  R_T1,  R_T2);
      7'd30: u = mk(OP_DIV, R_K00, R_T1,  R_DET);
      7'd31: u = mk(OP_MUL, R_T1,  R_P1,  R_S00);
      7'd32: u = mk(OP_MUL, R_T2,  R_P0,  R_P1);
      7'd33: u = mk(OP_SUB, R_T1,  R_T1,  R_T2);
      7'd34: u = mk(OP_DIV, R_K01, R_T1,  R_DET);
      7'd35: u = mk(OP_MUL, R_T1,  R_P2,  R_S11);
      7'd36: u = mk(OP_MUL, R_T2,  R_P3,  R_P2);
      7'd37: u = mk(OP_SUB, R_T1,  R_T1,  R_T2);
      7'd38: u = mk(OP_DIV, R_K10, R_T1,  R_DET);
      7'd39: u = mk(OP_MUL, R_T1,  R_P3,  R_S00);
      7'd40: u = mk(OP_MUL, R_T2,  R_P2,  R_P1);
      7'd41: u = mk(OP_SUB, R_T1,  R_T1,  R_T2);
      7'd42: u = mk(OP_DIV, R_K11, R_T1,  R_DET);
      7'd43: u = mk(OP_SUB, R_Y0,  R_ZD,  R_X0);
      7'd44: u = mk(OP_SUB, R_Y1,  R_ZV,  R_X1);
      7'd45: u = mk(OP_MUL, R_T1,  R_K00, R_Y0);
      7'd46: u = mk(OP_MUL, R_T2,  R_K01, R_Y1);
      7'd47: u = mk(OP_ADD, R_T1,  R_T1,  R_T2);
      7'd48: u = mk(OP_ADD, R_X0,  R_X0,  R_T1);
      7'd49: u = mk(OP_MUL, R_T1,  R_K10, R_Y0);
      7'd50: u = mk(OP_MUL, R_T2,  R_K11, R_Y1);
      7'd51: u = mk(OP_ADD, R_T1,  R_T1,  R_T2);
      7'd52: u = mk(OP_ADD, R_X1,  R_X1,  R_T1);
      7'd53: u = mk(OP_MUL, R_T1,  R_K00, R_P0);
      7'd54: u = mk(OP_MUL, R_T2,  R_K01, R_P2);
      7'd55: u = mk(OP_ADD, R_T1,  R_T1,  R_T2);
      7'd56: u = mk(OP_SUB, R_N00, R_P0,  R_T1);
      7'd57: u = mk(OP_MUL, R_T1,  R_K00, R_P1);
      7'd58: u = mk(OP_MUL, R_T2,  R_K01, R_P3);
      7'd59: u = mk(OP_ADD, R_T1,  R_T1,  R_T2);
      7'd60: u = mk(OP_SUB, R_N01, R_P1,  R_T1);
      7'd61: u = mk(OP_MUL, R_T1,  R_K10, R_P0);
      7'd62: u = mk(OP_MUL, R_T2,  R_K11, R_P2);
      7'd63: u = mk(OP_ADD, R_T1,  R_T1,  R_T2);
      7'd64: u = mk(OP_SUB, R_N10, R_P2,  R_T1);
      7'd65: u = mk(OP_MUL, R_T1,  R_K10, R_P1);
      7'd66: u = mk(OP_MUL, R_T2,  R_K11, R_P3);
      7'd67: u = mk(OP_ADD, R_T1,  R_T1,  R_T2);
      7'd68: u = mk(OP_SUB, R_P3,  R_P3,  R_T1);
      7'd69: u = mk(OP_CPY, R_T1,  R_T1,  R_T1);
      default: u = mk(OP_END, R_T1,  R_T1,  R_T1);
    endcase
    return u;
  endfunction

endpackage

>>> design/kf2_div.sv
module kf2_div
  import kf2_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output div_res_t          res
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_RND} dstate_t;

  dstate_t              state_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_STEPS-1:0] nq_r;
  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W-1:0]    d_r;
  logic                 neg_r;
  div_res_t             res_r;

  logic [DATA_W:0]      rem_sh;
  logic                 ge;
  logic [DATA_W:0]      rem_nxt;
  logic [DATA_W-1:0]    mag_n;
  logic [DATA_W-1:0]    mag_d;
  logic                 rnd_up;
  logic [MAG_W-1:0]     q_fin;
  fx_res_t              fin;

  assign mag_n   = num[DATA_W-1] ? (DATA_W'(0) - num) : num;
  assign mag_d   = den[DATA_W-1] ? (DATA_W'(0) - den) : den;
  assign rem_sh  = {rem_r, nq_r[DIV_STEPS-1]};
  assign ge      = (rem_sh >= {1'b0, d_r});
  assign rem_nxt = ge ? (rem_sh - {1'b0, d_r}) : rem_sh;
  assign rnd_up  = ({1'b0, rem_r} >= ({1'b0, d_r} - {1'b0, rem_r}));
  assign q_fin   = (d_r == '0) ? {MAG_W{1'b1}} : ({1'b0, nq_r} + MAG_W'(rnd_up));
  assign fin     = sat_mag(q_fin, neg_r);
  assign res     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= D_IDLE;
      cnt_r    <= '0;
      res_r    <= '0;
    end else begin
      res_r.done <= (state_r == D_RND);
      unique case (state_r)
        D_IDLE: begin
          if (start) begin
            nq_r    <= {mag_n, FRAC_BITS'(0)};
            rem_r   <= '0;
            d_r     <= mag_d;
            neg_r   <= num[DATA_W-1] ^ den[DATA_W-1];
            cnt_r   <= '0;
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          rem_r <= rem_nxt[DATA_W-1:0];
          nq_r  <= {nq_r[DIV_STEPS-2:0], ge};
          cnt_r <= cnt_r + DIV_CNT_W'(1);
          if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
            state_r <= D_RND;
          end
        end
        D_RND: begin
          res_r.sat  <= fin.sat;
          res_r.quo  <= fin.val;
          state_r    <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
    end
  end

endmodule

>>> design/kalman_filter_pos_vel_2state.sv
// Two-state position and velocity Kalman filter in signed Q16.16.
// Input transactions arrive on the in_ stream: tuser carries the command
// (1 initialises the state from the measurements, 0 predicts and corrects),
// tdata the measured position, velocity and acceleration. Each input
// transaction yields exactly one output transaction on the out_ stream with
// the new position and velocity estimates and the singular and saturated flags.
// An initialise command's result is valid in the cycle after it is accepted.
// An update is run by a microcoded sequencer that drives one shared 32 by 32
// multiplier (product registered, then rounded and written back), one saturating
// adder and a restoring divider that produces one quotient bit a cycle (four gain terms).
// A singular innovation covariance ends the update early.
// One transaction is processed at a time; in_tready is low while an update is
// running or while a result still waits on out_tready. A stalled receiver holds
// the result and the block simply waits. Reset restores the default noise and
// time step registers, zeroes the state and sets the covariance to identity.
// The noise and time step registers are written over the APB-style cfg_ port.
module kalman_filter_pos_vel_2state
  import kf2_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // position_meas, velocity_meas, accel_input
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // position_est, velocity_est
  output logic [1:0]  out_tuser,  // singular_flag, saturated_flag
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MULW, S_DIVW} state_t;

  state_t             state_r;
  logic [PC_W-1:0]    pc_r;
  logic [DATA_W-1:0]  rf_r [NUM_RF];
  logic [2*DATA_W-1:0] prod_r;
  logic               neg_r;
  reg_id_t            dst_r;
  logic               sat_r;
  logic               sing_r;
  logic               out_valid_r;
  logic [63:0]        out_data_r;
  logic [1:0]         out_user_r;
  logic [15:0]        dt_r;
  logic [30:0]        rd_r;
  logic [30:0]        rv_r;
  logic [30:0]        qa_r;

  uop_t               uop;
  logic [DATA_W-1:0]  opa;
  logic [DATA_W-1:0]  opb;
  logic [DATA_W-1:0]  ma;
  logic [DATA_W-1:0]  mb;
  logic [DATA_W:0]    sum;
  logic [DATA_W-1:0]  sum_val;
  logic               sum_sat;
  logic [2*DATA_W:0]  prod_rnd;
  fx_res_t            mul_res;
  logic               div_start;
  div_res_t           div_res;
  logic               cfg_wr;
  logic               in_acc;

  function automatic logic [DATA_W-1:0] src(reg_id_t id, logic [DATA_W-1:0] rfv,
                                            logic [15:0] dt, logic [30:0] rd,
                                            logic [30:0] rv, logic [30:0] qa);
    logic [DATA_W-1:0] v;
    unique case (id)
      R_DT:    v = DATA_W'(dt);
      R_RD:    v = DATA_W'(rd);
      R_RV:    v = DATA_W'(rv);
      R_QA:    v = DATA_W'(qa);
      R_HALF:  v = FX_HALF;
      default: v = rfv;
    endcase
    return v;
  endfunction

  assign uop = ucode(pc_r);
  assign opa = src(uop.sa, rf_r[uop.sa], dt_r, rd_r, rv_r, qa_r);
  assign opb = src(uop.sb, rf_r[uop.sb], dt_r, rd_r, rv_r, qa_r);
  assign ma  = opa[DATA_W-1] ? (DATA_W'(0) - opa) : opa;
  assign mb  = opb[DATA_W-1] ? (DATA_W'(0) - opb) : opb;

  always_comb begin
    if (uop.op == OP_SUB) begin
      sum = {opa[DATA_W-1], opa} - {opb[DATA_W-1], opb};
    end else begin
      sum = {opa[DATA_W-1], opa} + {opb[DATA_W-1], opb};
    end
    sum_sat = sum[DATA_W] ^ sum[DATA_W-1];
    if (sum_sat) begin
      sum_val = sum[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sum_val = sum[DATA_W-1:0];
    end
  end

  assign prod_rnd = {1'b0, prod_r} + (2*DATA_W+1)'(FX_HALF);
  assign mul_res  = sat_mag(prod_rnd[FRAC_BITS +: MAG_W], neg_r);

  assign div_start = (state_r == S_EXEC) && (uop.op == OP_DIV);

  kf2_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (opa),
    .den   (opb),
    .res   (div_res)
  );

  assign in_tready  = (state_r == S_IDLE) && !out_valid_r;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_idx_t'(cfg_paddr[3:2]))
      CFG_TIME_STEP: cfg_prdata = 32'(dt_r);
      CFG_POS_SD:    cfg_prdata = 32'(rd_r);
      CFG_VEL_SD:    cfg_prdata = 32'(rv_r);
      CFG_PROC_SD:   cfg_prdata = 32'(qa_r);
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= DT_RESET;
      rd_r <= RD_RESET;
      rv_r <= RV_RESET;
      qa_r <= QA_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_paddr[3:2]))
        CFG_TIME_STEP: dt_r <= cfg_pwdata[15:0];
        CFG_POS_SD:    rd_r <= cfg_pwdata[30:0];
        CFG_VEL_SD:    rv_r <= cfg_pwdata[30:0];
        CFG_PROC_SD:   qa_r <= cfg_pwdata[30:0];
        default:       dt_r <= dt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= '0;
      sat_r       <= 1'b0;
      sing_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_RF; i++) begin
        rf_r[i] <= (i == int'(R_P0) || i == int'(R_P3)) ? FX_ONE : '0;
      end
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_tuser) begin
              rf_r[R_X0]  <= in_tdata[31:0];
              rf_r[R_X1]  <= in_tdata[63:32];
              rf_r[R_P0]  <= FX_ONE;
              rf_r[R_P1]  <= '0;
              rf_r[R_P2]  <= '0;
              rf_r[R_P3]  <= FX_ONE;
              out_data_r  <= in_tdata[63:0];
              out_user_r  <= 2'b00;
              out_valid_r <= 1'b1;
            end else begin
              rf_r[R_ZD] <= in_tdata[31:0];
              rf_r[R_ZV] <= in_tdata[63:32];
              rf_r[R_U]  <= in_tdata[95:64];
              pc_r       <= '0;
              sat_r      <= 1'b0;
              sing_r     <= 1'b0;
              state_r    <= S_EXEC;
            end
          end
        end
        S_EXEC: begin
          unique case (uop.op)
            OP_MUL: begin
              prod_r  <= ma * mb;
              neg_r   <= opa[DATA_W-1] ^ opb[DATA_W-1];
              dst_r   <= uop.dst;
              state_r <= S_MULW;
            end
            OP_ADD, OP_SUB: begin
              rf_r[uop.dst] <= sum_val;
              sat_r         <= sat_r | sum_sat;
              pc_r          <= pc_r + PC_W'(1);
            end
            OP_DIV: begin
              dst_r   <= uop.dst;
              state_r <= S_DIVW;
            end
            OP_CHK: begin
              if (opa == '0) begin
                sing_r      <= 1'b1;
                out_data_r  <= {rf_r[R_X1], rf_r[R_X0]};
                out_user_r  <= {sat_r, 1'b1};
                out_valid_r <= 1'b1;
                state_r     <= S_IDLE;
              end else begin
                pc_r <= pc_r + PC_W'(1);
              end
            end
            OP_CPY: begin
              rf_r[R_P0] <= rf_r[R_N00];
              rf_r[R_P1] <= rf_r[R_N01];
              rf_r[R_P2] <= rf_r[R_N10];
              pc_r       <= pc_r + PC_W'(1);
            end
            OP_END: begin
              out_data_r  <= {rf_r[R_X1], rf_r[R_X0]};
              out_user_r  <= {sat_r, sing_r};
              out_valid_r <= 1'b1;
              state_r     <= S_IDLE;
            end
            default: state_r <= S_IDLE;
          endcase
        end
        S_MULW: begin
          rf_r[dst_r] <= mul_res.val;
          sat_r       <= sat_r | mul_res.sat;
          pc_r        <= pc_r + PC_W'(1);
          state_r     <= S_EXEC;
        end
        S_DIVW: begin
          if (div_res.done) begin
            rf_r[dst_r] <= div_res.quo;
            sat_r       <= sat_r | div_res.sat;
            pc_r        <= pc_r + PC_W'(1);
            state_r     <= S_EXEC;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sim/tb_kalman_filter_pos_vel_2state.sv
`timescale 1ns / 1ps

module tb_kalman_filter_pos_vel_2state
  import kf2_pkg::*;
();

  typedef struct {
    bit          init;
    logic [31:0] pos;
    logic [31:0] vel;
    logic [31:0] acc;
  } meas_t;

  typedef struct {
    logic [31:0] pos;
    logic [31:0] vel;
    bit          singular;
    bit          saturated;
  } est_t;

  localparam longint VMAX = 64'sh7FFFFFFF;
  localparam longint ONE = 64'sd65536;
  localparam longint HALF = 64'sd32768;
  localparam int WATCHDOG_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  meas_t  meas_q[$];
  est_t   est_q[$];
  int     errors;
  int     idle_mode;
  int     holdoff_cnt;
  int     quiet_cnt;
  bit     in_fire;
  bit     sat_seen;

  longint kf_x0, kf_x1;
  longint kf_p[4];
  longint dt_reg, rd_reg, rv_reg, qa_reg;

  kalman_filter_pos_vel_2state uut (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic longint clampv(longint v);
    if (v > VMAX) begin
      sat_seen = 1'b1;
      return VMAX;
    end
    if (v < -VMAX - 1) begin
      sat_seen = 1'b1;
      return -VMAX - 1;
    end
    return v;
  endfunction

  function automatic longint from_mag(logic [127:0] m, bit neg);
    logic [127:0] lim;
    lim = neg ? 128'(VMAX) + 128'd1 : 128'(VMAX);
    if (m > lim) begin
      sat_seen = 1'b1;
      m = lim;
    end
    return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
  endfunction

  function automatic logic [127:0] mag(longint v);
    return (v < 0) ? 128'(-v) : 128'(v);
  endfunction

  function automatic longint fx_add(longint a, longint b);
    return clampv(a + b);
  endfunction

  function automatic longint fx_sub(longint a, longint b);
    return clampv(a - b);
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    logic [127:0] p;
    p = mag(a) * mag(b) + 128'd32768;
    return from_mag(p >> FRAC_BITS, (a < 0) != (b < 0));
  endfunction

  function automatic longint fx_div(longint a, longint b);
    logic [127:0] n, d, q, r;
    bit neg;
    neg = (a < 0) != (b < 0);
    n = mag(a) << FRAC_BITS;
    d = mag(b);
    if (d == 0)
      return from_mag({128{1'b1}}, neg);
    q = n / d;
    r = n % d;
    if (r >= d - r)
      q = q + 1;
    return from_mag(q, neg);
  endfunction

  function automatic est_t kalman_predict(meas_t m);
    longint zd, zv, u, b0, q, a00, a01, a10, a11, s00, s01, s10, s11, det;
    longint k00, k01, k10, k11, y0, y1, n00, n01, n10, n11;
    est_t e;
    sat_seen = 1'b0;
    e.singular = 1'b0;
    zd = longint'($signed(m.pos));
    zv = longint'($signed(m.vel));
    u = longint'($signed(m.acc));
    if (m.init) begin
      kf_x0 = zd;
      kf_x1 = zv;
      kf_p = '{ONE, 0, 0, ONE};
    end else begin
      b0 = fx_mul(fx_mul(dt_reg, dt_reg), HALF);
      q = fx_mul(qa_reg, qa_reg);
      kf_x0 = fx_add(fx_add(kf_x0, fx_mul(dt_reg, kf_x1)), fx_mul(b0, u));
      kf_x1 = fx_add(kf_x1, fx_mul(dt_reg, u));
      a00 = fx_add(kf_p[0], fx_mul(dt_reg, kf_p[2]));
      a01 = fx_add(kf_p[1], fx_mul(dt_reg, kf_p[3]));
      a10 = kf_p[2];
      a11 = kf_p[3];
      kf_p[0] = fx_add(fx_add(a00, fx_mul(a01, dt_reg)), q);
      kf_p[1] = a01;
      kf_p[2] = fx_add(a10, fx_mul(a11, dt_reg));
      kf_p[3] = fx_add(a11, q);
      s00 = fx_add(kf_p[0], fx_mul(rd_reg, rd_reg));
      s01 = kf_p[1];
      s10 = kf_p[2];
      s11 = fx_add(kf_p[3], fx_mul(rv_reg, rv_reg));
      det = fx_sub(fx_mul(s00, s11), fx_mul(s01, s10));
      if (det == 0) begin
        e.singular = 1'b1;
      end else begin
        k00 = fx_div(fx_sub(fx_mul(kf_p[0], s11), fx_mul(kf_p[1], s10)), det);
        k01 = fx_div(fx_sub(fx_mul(kf_p[1], s00), fx_mul(kf_p[0], s01)), det);
        k10 = fx_div(fx_sub(fx_mul(kf_p[2], s11), fx_mul(kf_p[3], s10)), det);
        k11 = fx_div(fx_sub(fx_mul(kf_p[3], s00), fx_mul(kf_p[2], s01)), det);
        y0 = fx_sub(zd, kf_x0);
        y1 = fx_sub(zv, kf_x1);
        kf_x0 = fx_add(kf_x0, fx_add(fx_mul(k00, y0), fx_mul(k01, y1)));
        kf_x1 = fx_add(kf_x1, fx_add(fx_mul(k10, y0), fx_mul(k11, y1)));
        n00 = fx_sub(kf_p[0], fx_add(fx_mul(k00, kf_p[0]), fx_mul(k01, kf_p[2])));
        n01 = fx_sub(kf_p[1], fx_add(fx_mul(k00, kf_p[1]), fx_mul(k01, kf_p[3])));
        n10 = fx_sub(kf_p[2], fx_add(fx_mul(k10, kf_p[0]), fx_mul(k11, kf_p[2])));
        n11 = fx_sub(kf_p[3], fx_add(fx_mul(k10, kf_p[1]), fx_mul(k11, kf_p[3])));
        kf_p = '{n00, n01, n10, n11};
      end
    end
    e.pos = kf_x0[31:0];
    e.vel = kf_x1[31:0];
    e.saturated = sat_seen;
    return e;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", field, got, want);
    errors++;
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      CFG_TIME_STEP: dt_reg = longint'(value[15:0]);
      CFG_POS_SD:    rd_reg = longint'(value[30:0]);
      CFG_VEL_SD:    rv_reg = longint'(value[30:0]);
      CFG_PROC_SD:   qa_reg = longint'(value[30:0]);
    endcase
  endtask

  task automatic set_noise(logic [15:0] dt, logic [30:0] rd, logic [30:0] rv,
                           logic [30:0] qa);
    cfg_write(CFG_TIME_STEP, {16'd0, dt});
    cfg_write(CFG_POS_SD, {1'b0, rd});
    cfg_write(CFG_VEL_SD, {1'b0, rv});
    cfg_write(CFG_PROC_SD, {1'b0, qa});
  endtask

  task automatic add_meas(bit init, logic [31:0] pos, logic [31:0] vel, logic [31:0] acc);
    meas_t m;
    m.init = init;
    m.pos = pos;
    m.vel = vel;
    m.acc = acc;
    meas_q.push_back(m);
  endtask

  function automatic logic [31:0] rand_value();
    logic [31:0] v;
    v = $urandom;
    if ($urandom_range(0, 7) != 0)
      v = $signed(v) >>> $urandom_range(4, 20);
    return v;
  endfunction

  task automatic add_random(int count);
    repeat (count)
      add_meas($urandom_range(0, 11) == 0, rand_value(), rand_value(), rand_value());
  endtask

  task automatic drain();
    while (meas_q.size() != 0 || in_tvalid || est_q.size() != 0)
      @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      est_q.push_back(kalman_predict('{in_tuser, in_tdata[31:0], in_tdata[63:32],
                                       in_tdata[95:64]}));
    if (rst_n && out_tvalid && out_tready) begin
      if (est_q.size() == 0) begin
        $display("result transaction with no estimate pending");
        errors++;
      end else begin
        est_t e;
        e = est_q.pop_front();
        if (out_tdata[31:0] !== e.pos) report_mismatch("position", out_tdata[31:0], e.pos);
        if (out_tdata[63:32] !== e.vel) report_mismatch("velocity", out_tdata[63:32], e.vel);
        if (out_tuser[0] !== e.singular)
          report_mismatch("singular", 32'(out_tuser[0]), 32'(e.singular));
        if (out_tuser[1] !== e.saturated)
          report_mismatch("saturated", 32'(out_tuser[1]), 32'(e.saturated));
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n && in_tvalid && !in_fire) begin
    end else if (rst_n && meas_q.size() != 0 &&
                 !((idle_mode == 1 || idle_mode == 3) &&
                   $urandom_range(0, 99) < (idle_mode == 1 ? 46 : 6))) begin
      meas_t m;
      m = meas_q.pop_front();
      in_tvalid <= 1'b1;
      in_tuser <= m.init;
      in_tdata <= {m.acc, m.vel, m.pos};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (holdoff_cnt > 0)
      holdoff_cnt <= holdoff_cnt - 1;
  end

  always @(negedge clk) begin
    out_tready <= (holdoff_cnt == 0) &&
                  !((idle_mode == 2 || idle_mode == 3) &&
                    $urandom_range(0, 99) < (idle_mode == 2 ? 46 : 6));
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG_LIMIT) begin
      $display("tb_kalman_filter_pos_vel_2state: errors");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_mode = 0;
    holdoff_cnt = 0;
    quiet_cnt = 0;
    in_fire = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    kf_x0 = 0;
    kf_x1 = 0;
    kf_p = '{ONE, 0, 0, ONE};
    dt_reg = longint'(DT_RESET);
    rd_reg = longint'(RD_RESET);
    rv_reg = longint'(RV_RESET);
    qa_reg = longint'(QA_RESET);
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset values first, then the extremes of every measurement field.
    add_meas(1'b0, 32'h0001_0000, 32'h0000_8000, 32'h0000_1000);
    add_meas(1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    add_meas(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_meas(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_meas(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_meas(1'b0, 32'h0, 32'h0, 32'h0);
    add_meas(1'b0, 32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
    add_meas(1'b1, 32'h0, 32'h0, 32'h0);
    add_meas(1'b0, 32'h0010_0000, 32'hFFF0_0000, 32'h0002_0000);
    add_meas(1'b0, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    add_meas(1'b0, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    drain();

    idle_mode = 1;
    add_random(400);
    drain();

    set_noise(16'hFFFF, 31'h7FFF_FFFF, 31'd0, 31'h7FFF_FFFF);
    idle_mode = 2;
    add_meas(1'b1, 32'h0, 32'h0, 32'h0);
    add_random(150);
    drain();

    // With no noise at all the covariance collapses and the
    // innovation covariance soon becomes singular.
    set_noise(16'd0, 31'd0, 31'd0, 31'd0);
    idle_mode = 3;
    add_meas(1'b1, 32'h0003_0000, 32'h0001_0000, 32'h0);
    repeat (10) add_meas(1'b0, rand_value(), rand_value(), rand_value());
    add_random(100);
    holdoff_cnt = 1500;
    drain();

    set_noise(16'($urandom_range(1, 8000)), 31'($urandom_range(1, 1 << 20)),
              31'($urandom_range(1, 1 << 18)), 31'($urandom_range(1, 1 << 14)));
    add_random(400);
    drain();

    set_noise(DT_RESET, RD_RESET, RV_RESET, QA_RESET);
    idle_mode = 0;
    add_random(480);
    drain();

    if (errors == 0 && est_q.size() == 0)
      $display("tb_kalman_filter_pos_vel_2state: clean");
    else
      $display("tb_kalman_filter_pos_vel_2state: errors");
    $finish;
  end

endmodule
